// ===== hw/rtl/dfr_pkg.sv =====
// Shared types, codes and helper functions of the stream deframer.
package dfr_pkg;

    localparam logic [7:0] PREAMBLE = 8'h55;
    localparam logic [7:0] DOLLAR   = 8'h24;
    localparam logic [7:0] CR_CHAR  = 8'h0D;
    localparam logic [7:0] LF_CHAR  = 8'h0A;
    localparam logic [15:0] CRC_INIT = 16'h1D0F;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [1:0] CMD_PUSH     = 2'd0;
    localparam logic [1:0] CMD_READ_PKT = 2'd1;
    localparam logic [1:0] CMD_READ_SEN = 2'd2;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_PKT_GOOD = 3'd1;
    localparam logic [2:0] EV_PKT_CRC  = 3'd2;
    localparam logic [2:0] EV_SENTENCE = 3'd3;
    localparam logic [2:0] EV_READ     = 3'd4;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_NAME = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    // where the read byte of a result comes from
    typedef enum logic [1:0] {
        SRC_FIELD = 2'd0,
        SRC_PKT   = 2'd1,
        SRC_SEN   = 2'd2
    } rd_src_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [2:0] packet_kind;
        logic [7:0] payload_length;
        logic [7:0] sentence_length;
        logic [7:0] read_byte;
    } result_t;

    // bytewise CRC-16, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // packet type lookup; hit flag in bit 3, index below
    function automatic logic [3:0] kind_lookup(input logic [7:0] c0, input logic [7:0] c1);
        logic [3:0] r;
        r = 4'd0;
        unique case ({c0, c1})
            {8'h73, 8'h31}: r = {1'b1, 3'd0};
            {8'h4B, 8'h31}: r = {1'b1, 3'd1};
            {8'h70, 8'h53}: r = {1'b1, 3'd2};
            {8'h73, 8'h4B}: r = {1'b1, 3'd3};
            {8'h69, 8'h4E}: r = {1'b1, 3'd4};
            {8'h64, 8'h31}: r = {1'b1, 3'd5};
            {8'h67, 8'h4E}: r = {1'b1, 3'd6};
            default:        r = 4'd0;
        endcase
        return r;
    endfunction

    // five characters after the dollar against the ten talker names
    function automatic logic name_match(input logic [39:0] n);
        logic m;
        unique case (n)
            "GPGGA", "GPRMC", "GPGSV", "GLGSV", "GAGSV",
            "BDGSV", "GPGSA", "GLGSA", "GAGSA", "BDGSA": m = 1'b1;
            default: m = 1'b0;
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/dfr_front.sv =====
// Front end: byte parsing, packet and sentence stores, one result per beat.
module dfr_front #(
    parameter int PACKET_DEPTH   = 512,
    parameter int SENTENCE_DEPTH = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       command,
    input  logic [7:0]       data_byte,
    input  logic [8:0]       read_index,
    output logic             res_valid,
    output dfr_pkg::result_t res
);
    import dfr_pkg::*;

    localparam int PA = $clog2(PACKET_DEPTH);
    localparam int SA = $clog2(SENTENCE_DEPTH);
    localparam int SW = $clog2(SENTENCE_DEPTH + 1);

    logic [7:0] pmem [PACKET_DEPTH];
    logic [7:0] smem [SENTENCE_DEPTH];

    // parser state
    logic [2:0]  hc_reg, hc_next;
    logic [7:0]  t0_reg, t0_next;
    logic [15:0] crcpre_reg, crcpre_next;
    logic        inpkt_reg, inpkt_next;
    logic [8:0]  pcount_reg, pcount_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  hi_reg, hi_next;
    logic [7:0]  pkt0_reg, pkt0_next;
    logic [2:0]  kind_reg, kind_next;
    logic [1:0]  phase_reg, phase_next;
    logic [SW-1:0] scount_reg, scount_next;
    logic [31:0] name_reg, name_next;
    logic [7:0]  prev_reg, prev_next;

    // memory write and read controls
    logic          pwe, swe;
    logic [PA-1:0] pwa;
    logic [SA-1:0] swa;
    logic [7:0]    swd;
    logic [7:0]    prd_reg, srd_reg;

    // result stage
    logic    s1_valid_reg;
    result_t s1_res_reg, s0_res;
    rd_src_t s1_src_reg, s0_src;

    logic [3:0]  klu;
    logic [9:0]  len_ext;
    logic [9:0]  pos_ext;

    always_comb
    begin
        hc_next     = hc_reg;
        t0_next     = t0_reg;
        crcpre_next = crcpre_reg;
        inpkt_next  = inpkt_reg;
        pcount_next = pcount_reg;
        crc_next    = crc_reg;
        len_next    = len_reg;
        hi_next     = hi_reg;
        pkt0_next   = pkt0_reg;
        kind_next   = kind_reg;
        phase_next  = phase_reg;
        scount_next = scount_reg;
        name_next   = name_reg;
        prev_next   = prev_reg;
        pwe = 1'b0;
        pwa = '0;
        swe = 1'b0;
        swa = '0;
        swd = data_byte;
        s0_res = '0;
        s0_src = SRC_FIELD;
        klu = kind_lookup(t0_reg, data_byte);
        len_ext = {2'b00, len_reg};
        pos_ext = {1'b0, pcount_reg};

        if (in_valid) begin
            case (command)
                CMD_READ_PKT:
                begin
                    s0_res.event_res = EV_READ;
                    if (32'(read_index) >= PACKET_DEPTH)
                        s0_src = SRC_FIELD;
                    else if (read_index == 9'd0) begin
                        s0_res.read_byte = pkt0_reg;
                        s0_src = SRC_FIELD;
                    end else
                        s0_src = SRC_PKT;
                end
                CMD_READ_SEN:
                begin
                    s0_res.event_res = EV_READ;
                    s0_src = (32'(read_index) < SENTENCE_DEPTH) ? SRC_SEN : SRC_FIELD;
                end
                CMD_PUSH:
                begin
                    if (!inpkt_reg) begin
                        // header hunter
                        hc_next = hc_reg + 3'd1;
                        if ((hc_next == 3'd1 || hc_next == 3'd2) && data_byte != PREAMBLE)
                            hc_next = 3'd0;
                        if (hc_next == 3'd3) begin
                            t0_next = data_byte;
                            crcpre_next = crc_byte(CRC_INIT, data_byte);
                        end
                        if (hc_next == 3'd4) begin
                            hc_next = 3'd0;
                            if (klu[3]) begin
                                inpkt_next  = 1'b1;
                                kind_next   = klu[2:0];
                                pkt0_next   = t0_reg;
                                pwe         = 1'b1;
                                pwa         = PA'(1);
                                pcount_next = 9'd2;
                                crc_next    = crc_byte(crcpre_reg, data_byte);
                            end
                        end
                        // sentence hunter
                        case (phase_reg)
                            PH_HUNT:
                            begin
                                if (data_byte == DOLLAR) begin
                                    phase_next  = PH_NAME;
                                    swe         = 1'b1;
                                    swa         = '0;
                                    scount_next = SW'(1);
                                    prev_next   = data_byte;
                                end
                            end
                            PH_NAME:
                            begin
                                swe         = 1'b1;
                                swa         = SA'(scount_reg);
                                scount_next = scount_reg + SW'(1);
                                prev_next   = data_byte;
                                name_next   = {name_reg[23:0], data_byte};
                                if (scount_next == SW'(6))
                                    phase_next = name_match({name_reg, data_byte})
                                                 ? PH_BODY : PH_HUNT;
                            end
                            default:
                            begin
                                if (32'(scount_reg) >= SENTENCE_DEPTH)
                                    phase_next = PH_HUNT;
                                else begin
                                    swe         = 1'b1;
                                    swa         = SA'(scount_reg);
                                    scount_next = scount_reg + SW'(1);
                                    prev_next   = data_byte;
                                    if (data_byte == LF_CHAR && prev_reg == CR_CHAR) begin
                                        phase_next = PH_HUNT;
                                        s0_res.event_res = EV_SENTENCE;
                                        s0_res.sentence_length = 8'(scount_reg);
                                    end
                                end
                            end
                        endcase
                    end else begin
                        // packet body
                        pwe = 1'b1;
                        pwa = PA'(pcount_reg);
                        pcount_next = pcount_reg + 9'd1;
                        if (pcount_reg == 9'd2) begin
                            len_next = data_byte;
                            crc_next = crc_byte(crc_reg, data_byte);
                        end else if (pos_ext < len_ext + 10'd3)
                            crc_next = crc_byte(crc_reg, data_byte);
                        if (pcount_reg >= 9'd3 && pos_ext == len_ext + 10'd3)
                            hi_next = data_byte;
                        if (pcount_reg >= 9'd3 && pos_ext == len_ext + 10'd4) begin
                            s0_res.event_res = ({hi_reg, data_byte} == crc_reg)
                                               ? EV_PKT_GOOD : EV_PKT_CRC;
                            s0_res.packet_kind    = kind_reg;
                            s0_res.payload_length = len_reg;
                            inpkt_next  = 1'b0;
                            pcount_next = 9'd0;
                            crc_next    = CRC_INIT;
                        end
                    end
                end
                default:
                begin
                    s0_res = '0;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hc_reg       <= '0;
            t0_reg       <= '0;
            crcpre_reg   <= CRC_INIT;
            inpkt_reg    <= 1'b0;
            pcount_reg   <= '0;
            crc_reg      <= CRC_INIT;
            len_reg      <= '0;
            hi_reg       <= '0;
            pkt0_reg     <= '0;
            kind_reg     <= '0;
            phase_reg    <= PH_HUNT;
            scount_reg   <= '0;
            name_reg     <= '0;
            prev_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            hc_reg       <= hc_next;
            t0_reg       <= t0_next;
            crcpre_reg   <= crcpre_next;
            inpkt_reg    <= inpkt_next;
            pcount_reg   <= pcount_next;
            crc_reg      <= crc_next;
            len_reg      <= len_next;
            hi_reg       <= hi_next;
            pkt0_reg     <= pkt0_next;
            kind_reg     <= kind_next;
            phase_reg    <= phase_next;
            scount_reg   <= scount_next;
            name_reg     <= name_next;
            prev_reg     <= prev_next;
            s1_valid_reg <= in_valid;
        end
    end

    // result payload of the stage
    always_ff @(posedge clk)
    begin
        s1_res_reg <= s0_res;
        s1_src_reg <= s0_src;
    end

    // stores, registered read
    always_ff @(posedge clk)
    begin
        if (pwe)
            pmem[pwa] <= data_byte;
        prd_reg <= pmem[PA'(read_index)];
    end

    always_ff @(posedge clk)
    begin
        if (swe)
            smem[swa] <= swd;
        srd_reg <= smem[SA'(read_index)];
    end

    // merge read data
    always_comb
    begin
        res = s1_res_reg;
        case (s1_src_reg)
            SRC_PKT: res.read_byte = prd_reg;
            SRC_SEN: res.read_byte = srd_reg;
            default: res.read_byte = s1_res_reg.read_byte;
        endcase
    end

    assign res_valid = s1_valid_reg;

endmodule

// ===== hw/rtl/dfr_queue.sv =====
// Result queue between the front end and the output side.
module dfr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  dfr_pkg::result_t wdata,
    input  logic             rd,
    output dfr_pkg::result_t rdata,
    output logic             empty,
    output logic [2:0]       count
);
    import dfr_pkg::*;

    result_t    mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       do_rd;

    assign do_rd = rd && (cnt_reg != 3'd0);

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr)
                wp_reg <= wp_reg + 2'd1;
            if (do_rd)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b00, wr} - {2'b00, do_rd};
        end
    end

    // entries
    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wdata;
    end

    assign rdata = mem_reg[rp_reg];
    assign empty = (cnt_reg == 3'd0);
    assign count = cnt_reg;

endmodule

// ===== hw/rtl/binary_and_nmea_stream_deframer_core.sv =====
// Top level of the binary packet and NMEA sentence deframer.
//  channel | direction | handshake    | fields
//  input   | in        | push / full  | command, data_byte, read_index
//  result  | out       | pop / empty  | event_res, packet_kind, payload_length,
//          |           |              | sentence_length, read_byte
// One beat is accepted per cycle while full is low; each beat yields one result,
// registered together with the registered read of the packet and sentence stores.
// Results wait in a four-entry queue; full rises when queue plus the beat in
// flight fill it. Reset clears the parser and queue; the stores are not cleared.
module binary_and_nmea_stream_deframer_core #(
    parameter int PACKET_DEPTH   = 512,
    parameter int SENTENCE_DEPTH = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] command,
    input  logic [7:0] data_byte,
    input  logic [8:0] read_index,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] event_res,
    output logic [2:0] packet_kind,
    output logic [7:0] payload_length,
    output logic [7:0] sentence_length,
    output logic [7:0] read_byte
);
    import dfr_pkg::*;

    logic       accept;
    logic       res_valid;
    result_t    res, head;
    logic [2:0] q_count;

    assign accept = push && !full;
    assign full   = ({1'b0, q_count} + {3'b000, res_valid}) >= 4'd4;

    dfr_front #(
        .PACKET_DEPTH   (PACKET_DEPTH),
        .SENTENCE_DEPTH (SENTENCE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .command    (command),
        .data_byte  (data_byte),
        .read_index (read_index),
        .res_valid  (res_valid),
        .res        (res)
    );

    dfr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_valid),
        .wdata (res),
        .rd    (pop),
        .rdata (head),
        .empty (empty),
        .count (q_count)
    );

    assign event_res       = head.event_res;
    assign packet_kind     = head.packet_kind;
    assign payload_length  = head.payload_length;
    assign sentence_length = head.sentence_length;
    assign read_byte       = head.read_byte;

endmodule
